// File: rtl/hsa_pkg.sv
// ----------------------------------------------------------------------------
// hsa_pkg: shared types and codes for the Heron square-root block
// Status codes and the controller-to-datapath command and status structs.
// ----------------------------------------------------------------------------
package hsa_pkg;

    localparam int STATUS_WIDTH = 3;
    localparam int TOL_WIDTH    = 31;
    localparam int LIM_WIDTH    = 8;

    localparam logic [STATUS_WIDTH-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_BAD_TOL    = 3'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_NEG_GUESS  = 3'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_NEG_RAD    = 3'd3;
    localparam logic [STATUS_WIDTH-1:0] ST_ZERO_GUESS = 3'd4;
    localparam logic [STATUS_WIDTH-1:0] ST_LIMIT      = 3'd5;

    localparam logic CFG_TOLERANCE = 1'b0;
    localparam logic CFG_LIMIT     = 1'b1;

    // operation selector for the datapath
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,     // capture radicand and guess
        OP_DIV,      // start Heron quotient a*2^F/x0 or a*2^F/x1
        OP_STEP,     // x2 <= (x1 + q)/2
        OP_AIT_MUL,  // start product d1*d2 and tol*den
        OP_STEP0,    // x1 <= (x0 + q)/2 after first division
        OP_DIVN      // shift iterates down and start a*2^F/x2
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   div_from_x0;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;       // divider or multiplier running
        logic x1_eq_x0;
        logic ait_small;  // valid after OP_AIT_MUL completes
    } dp_stat_t;

endpackage

// File: rtl/hsa_datapath.sv
// ----------------------------------------------------------------------------
// hsa_datapath: iterates, shared restoring divider and shift-add multiplier
// One quotient bit or one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module hsa_datapath #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  hsa_pkg::dp_cmd_t                    cmd,
    input  logic [VALUE_WIDTH-1:0]              radicand,
    input  logic [VALUE_WIDTH-1:0]              guess,
    input  logic [hsa_pkg::TOL_WIDTH-1:0]       tolerance,
    output hsa_pkg::dp_stat_t                   stat,
    output logic [VALUE_WIDTH-1:0]              x2_out
);

    localparam int DIV_STEPS = VALUE_WIDTH - 1 + FRAC_BITS;
    localparam int DCW       = $clog2(DIV_STEPS + 1);
    localparam int MW        = (VALUE_WIDTH > hsa_pkg::TOL_WIDTH)
                               ? VALUE_WIDTH + 1 : hsa_pkg::TOL_WIDTH + 1;
    localparam int MCW       = $clog2(MW + 1);
    localparam int PW        = 2 * MW;
    localparam logic [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    logic [VALUE_WIDTH-1:0] a_reg, x0_reg, x1_reg, x2_reg;
    logic [VALUE_WIDTH-1:0] dsor_reg;
    logic [DIV_STEPS-1:0]   dividend_reg;
    logic [VALUE_WIDTH:0]   rem_reg;
    logic [VALUE_WIDTH:0]   q_reg;
    logic                   sat_reg;
    logic [DCW-1:0]         dcnt_reg;
    logic                   dbusy_reg;

    logic [MW-1:0]          pa_reg, pb_reg, ta_reg, tb_reg;
    logic [PW-1:0]          pacc_reg, tacc_reg;
    logic [MCW-1:0]         mcnt_reg;
    logic                   mbusy_reg;
    logic                   den_zero_reg;

    logic [VALUE_WIDTH:0]   rem_sh;
    logic                   take;
    logic [VALUE_WIDTH:0]   q_sh;
    logic [VALUE_WIDTH-1:0] quot;
    logic [VALUE_WIDTH:0]   heron_sum;
    logic [VALUE_WIDTH-1:0] heron_x;
    logic [MW-1:0]          d1, d2, s02, t2, den;

    // long-division step
    always_comb begin
        rem_sh = {rem_reg[VALUE_WIDTH-1:0], dividend_reg[DIV_STEPS-1]};
        take   = (rem_sh >= {1'b0, dsor_reg});
        q_sh   = {q_reg[VALUE_WIDTH-1:0], take};
    end

    assign quot      = (dsor_reg == '0 || sat_reg) ? VMAX : q_reg[VALUE_WIDTH-1:0];
    assign heron_sum = {1'b0, (cmd.op == hsa_pkg::OP_STEP0) ? x0_reg : x1_reg}
                       + {1'b0, quot};
    assign heron_x   = heron_sum[VALUE_WIDTH:1];

    always_comb begin
        d1  = (x1_reg >= x0_reg) ? MW'(x1_reg - x0_reg) : MW'(x0_reg - x1_reg);
        d2  = (x2_reg >= x1_reg) ? MW'(x2_reg - x1_reg) : MW'(x1_reg - x2_reg);
        s02 = MW'(x0_reg) + MW'(x2_reg);
        t2  = MW'({x1_reg, 1'b0});
        den = (t2 >= s02) ? (t2 - s02) : (s02 - t2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            mbusy_reg <= 1'b0;
        end else begin
            case (cmd.op)
                hsa_pkg::OP_LOAD: begin
                    a_reg  <= radicand;
                    x0_reg <= guess;
                end
                hsa_pkg::OP_DIV: begin
                    dsor_reg     <= cmd.div_from_x0 ? x0_reg : x1_reg;
                    dividend_reg <= {a_reg[VALUE_WIDTH-2:0], {FRAC_BITS{1'b0}}};
                    rem_reg      <= '0;
                    q_reg        <= '0;
                    sat_reg      <= 1'b0;
                    dcnt_reg     <= DCW'(DIV_STEPS);
                    dbusy_reg    <= 1'b1;
                end
                hsa_pkg::OP_DIVN: begin
                    // advance the window and divide by the newest iterate
                    x0_reg       <= x1_reg;
                    x1_reg       <= x2_reg;
                    dsor_reg     <= x2_reg;
                    dividend_reg <= {a_reg[VALUE_WIDTH-2:0], {FRAC_BITS{1'b0}}};
                    rem_reg      <= '0;
                    q_reg        <= '0;
                    sat_reg      <= 1'b0;
                    dcnt_reg     <= DCW'(DIV_STEPS);
                    dbusy_reg    <= 1'b1;
                end
                hsa_pkg::OP_STEP0: x1_reg <= heron_x;
                hsa_pkg::OP_STEP:  x2_reg <= heron_x;
                hsa_pkg::OP_AIT_MUL: begin
                    pa_reg       <= d1;
                    pb_reg       <= d2;
                    ta_reg       <= MW'(tolerance);
                    tb_reg       <= den;
                    pacc_reg     <= '0;
                    tacc_reg     <= '0;
                    mcnt_reg     <= MCW'(MW);
                    den_zero_reg <= (den == '0);
                    mbusy_reg    <= 1'b1;
                end
                default: ;
            endcase
            if (dbusy_reg) begin
                rem_reg      <= take ? (rem_sh - {1'b0, dsor_reg}) : rem_sh;
                dividend_reg <= {dividend_reg[DIV_STEPS-2:0], 1'b0};
                if (!sat_reg) begin
                    q_reg <= q_sh;
                    if (q_sh > {1'b0, VMAX}) sat_reg <= 1'b1;
                end
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == DCW'(1)) dbusy_reg <= 1'b0;
            end
            if (mbusy_reg) begin
                // shift-add, MSB of multiplier first
                pacc_reg <= {pacc_reg[PW-2:0], 1'b0}
                            + (pb_reg[MW-1] ? PW'(pa_reg) : '0);
                tacc_reg <= {tacc_reg[PW-2:0], 1'b0}
                            + (tb_reg[MW-1] ? PW'(ta_reg) : '0);
                pb_reg   <= {pb_reg[MW-2:0], 1'b0};
                tb_reg   <= {tb_reg[MW-2:0], 1'b0};
                mcnt_reg <= mcnt_reg - 1'b1;
                if (mcnt_reg == MCW'(1)) mbusy_reg <= 1'b0;
            end
        end
    end

    assign stat.busy      = dbusy_reg | mbusy_reg;
    assign stat.x1_eq_x0  = (x1_reg == x0_reg);
    assign stat.ait_small = !den_zero_reg && (pacc_reg < tacc_reg);
    assign x2_out         = x2_reg;

endmodule

// File: rtl/hsa_ctrl.sv
// ----------------------------------------------------------------------------
// hsa_ctrl: sequencer for Heron iterations and the Aitken stop test
// Screens the operands, issues divisions and products, builds the result.
// ----------------------------------------------------------------------------
module hsa_ctrl #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [VALUE_WIDTH-1:0]            s_radicand,
    input  logic [VALUE_WIDTH-1:0]            s_initial_guess,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [VALUE_WIDTH-1:0]            m_root,
    output logic [hsa_pkg::STATUS_WIDTH-1:0]  m_status,
    input  logic [hsa_pkg::TOL_WIDTH-1:0]     tolerance,
    input  logic [hsa_pkg::LIM_WIDTH-1:0]     iteration_limit,
    output hsa_pkg::dp_cmd_t                  cmd,
    input  hsa_pkg::dp_stat_t                 stat,
    input  logic [VALUE_WIDTH-1:0]            x2
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV0, S_WAIT0, S_DIV1, S_WAIT1,
        S_TEST, S_WAITM, S_DECIDE, S_DIVN, S_WAITN, S_OUT
    } state_t;

    state_t                                state_reg;
    logic [hsa_pkg::LIM_WIDTH-1:0]         count_reg;
    logic                                  m_valid_reg;
    logic [VALUE_WIDTH-1:0]                root_reg;
    logic [hsa_pkg::STATUS_WIDTH-1:0]      status_reg;
    logic [VALUE_WIDTH-1:0]                m_root_reg;
    logic [hsa_pkg::STATUS_WIDTH-1:0]      m_status_reg;
    logic                                  accept;
    logic                                  out_load;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    // hand the finished item to the output register once it is free
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        cmd.op          = hsa_pkg::OP_NONE;
        cmd.div_from_x0 = 1'b0;
        case (state_reg)
            S_IDLE:  if (accept) cmd.op = hsa_pkg::OP_LOAD;
            S_DIV0:  begin cmd.op = hsa_pkg::OP_DIV; cmd.div_from_x0 = 1'b1; end
            S_WAIT0: if (!stat.busy) cmd.op = hsa_pkg::OP_STEP0;
            S_DIV1:  cmd.op = hsa_pkg::OP_DIV;
            S_WAIT1: if (!stat.busy) begin
                cmd.op = hsa_pkg::OP_STEP; cmd.div_from_x0 = 1'b1;
            end
            S_TEST:  if (count_reg < iteration_limit && !stat.x1_eq_x0)
                cmd.op = hsa_pkg::OP_AIT_MUL;
            S_DIVN:  cmd.op = hsa_pkg::OP_DIVN;
            S_WAITN: if (!stat.busy) cmd.op = hsa_pkg::OP_STEP;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg  <= 1'b1;
                m_root_reg   <= root_reg;
                m_status_reg <= status_reg;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: if (accept) begin
                    root_reg  <= '0;
                    count_reg <= hsa_pkg::LIM_WIDTH'(2);
                    if (tolerance == '0) begin
                        status_reg <= hsa_pkg::ST_BAD_TOL; state_reg <= S_OUT;
                    end else if (s_initial_guess[VALUE_WIDTH-1]) begin
                        status_reg <= hsa_pkg::ST_NEG_GUESS; state_reg <= S_OUT;
                    end else if (s_radicand[VALUE_WIDTH-1]) begin
                        status_reg <= hsa_pkg::ST_NEG_RAD; state_reg <= S_OUT;
                    end else if (s_initial_guess == '0) begin
                        status_reg <= hsa_pkg::ST_ZERO_GUESS; state_reg <= S_OUT;
                    end else begin
                        status_reg <= hsa_pkg::ST_LIMIT; state_reg <= S_DIV0;
                    end
                end
                S_DIV0:  state_reg <= S_WAIT0;
                S_WAIT0: if (!stat.busy) state_reg <= S_DIV1;
                S_DIV1:  state_reg <= S_WAIT1;
                S_WAIT1: if (!stat.busy) state_reg <= S_TEST;
                S_TEST: begin
                    if (count_reg >= iteration_limit) begin
                        root_reg <= x2; state_reg <= S_OUT;
                    end else if (stat.x1_eq_x0) begin
                        root_reg <= x2; status_reg <= hsa_pkg::ST_OK;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_WAITM;
                    end
                end
                S_WAITM: if (!stat.busy) state_reg <= S_DECIDE;
                S_DECIDE: begin
                    if (stat.ait_small) begin
                        root_reg <= x2; status_reg <= hsa_pkg::ST_OK;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_DIVN;
                    end
                end
                S_DIVN:  state_reg <= S_WAITN;
                S_WAITN: if (!stat.busy) begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_TEST;
                end
                S_OUT: if (out_load) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_root   = m_root_reg;
    assign m_status = m_status_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("input taken twice in a row");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_root) && $stable(m_status)))
        else $error("result changed while stalled");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != hsa_pkg::ST_OK && m_status != hsa_pkg::ST_LIMIT)
        |-> (m_root == '0)) else $error("error status with nonzero root");

endmodule

// File: rtl/heron_sqrt_with_aitken_stop.sv
// ----------------------------------------------------------------------------
// heron_sqrt_with_aitken_stop: Heron square root with Aitken stop test
// Signed fixed-point root by Newton steps, one result beat per input beat.
// ----------------------------------------------------------------------------
// One item is worked at a time. Each Heron step costs one division through a
// shared restoring divider at one quotient bit a cycle; each stop test costs a
// shift-add product pass. An item runs two opening steps, then rounds of stop
// test and step until the test passes or the iteration limit is reached (reset
// limit 32); a limit of two or less runs only the two opening steps. Rejected
// operands go straight to the result without any iteration. A finished result
// sits in an output register, so the next item can be taken and worked while it
// waits. Configuration writes are taken at any time and should only be issued
// while idle.
module heron_sqrt_with_aitken_stop #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [VALUE_WIDTH-1:0]    s_radicand,
    input  logic signed [VALUE_WIDTH-1:0]    s_initial_guess,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [VALUE_WIDTH-1:0]    m_root,
    output logic [hsa_pkg::STATUS_WIDTH-1:0] m_status,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [31:0]                      cfg_data
);

    logic [hsa_pkg::TOL_WIDTH-1:0] tol_reg;
    logic [hsa_pkg::LIM_WIDTH-1:0] lim_reg;
    hsa_pkg::dp_cmd_t              cmd;
    hsa_pkg::dp_stat_t             stat;
    logic [VALUE_WIDTH-1:0]        x2;
    logic [VALUE_WIDTH-1:0]        root_u;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= hsa_pkg::TOL_WIDTH'(66);
            lim_reg <= hsa_pkg::LIM_WIDTH'(32);
        end else if (cfg_valid) begin
            case (cfg_index)
                hsa_pkg::CFG_TOLERANCE: tol_reg <= cfg_data[hsa_pkg::TOL_WIDTH-1:0];
                hsa_pkg::CFG_LIMIT:     lim_reg <= cfg_data[hsa_pkg::LIM_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    hsa_ctrl #(.VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready,
        .s_radicand(s_radicand), .s_initial_guess(s_initial_guess),
        .m_valid, .m_ready, .m_root(root_u), .m_status,
        .tolerance(tol_reg), .iteration_limit(lim_reg),
        .cmd, .stat, .x2
    );

    hsa_datapath #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk, .aresetn, .cmd,
        .radicand(s_radicand), .guess(s_initial_guess),
        .tolerance(tol_reg), .stat, .x2_out(x2)
    );

    assign m_root = root_u;

endmodule

// File: dv/heron_sqrt_with_aitken_stop_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heron_sqrt_with_aitken_stop_test: self-checking bench for the Heron root
// Drives radicand/guess beats and compares every root/status beat against an
// in-bench fixed-point model of the Heron iteration with its Aitken stop. Also
// covers both register settings, back-pressure, drain pauses and random data.
// ----------------------------------------------------------------------------
module heron_sqrt_with_aitken_stop_test;

    localparam int          WDOG_LIMIT = 200000;
    localparam int          FRAC_BITS  = 16;
    localparam logic [63:0] ROOT_MAX   = 64'h7FFF_FFFF;

    typedef struct packed {
        logic [31:0]                      root;
        logic [hsa_pkg::STATUS_WIDTH-1:0] status;
    } root_beat_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic signed [31:0]               s_radicand = '0;
    logic signed [31:0]               s_initial_guess = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic signed [31:0]               m_root;
    logic [hsa_pkg::STATUS_WIDTH-1:0] m_status;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic                             cfg_index = hsa_pkg::CFG_TOLERANCE;
    logic [31:0]                      cfg_data = '0;

    logic [hsa_pkg::TOL_WIDTH-1:0]    tol_q = 31'd66;
    logic [hsa_pkg::LIM_WIDTH-1:0]    lim_q = 8'd32;
    root_beat_t                       pending_roots[$];
    int                               mismatches = 0;
    int                               roots_seen = 0;
    int                               items_sent = 0;
    int                               cfg_writes = 0;
    int                               hold_off = 0;
    bit                               calm = 1'b0;
    int                               idle_cycles = 0;
    int                               ready_run = 0;
    bit                               ready_idle = 1'b0;

    heron_sqrt_with_aitken_stop dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_radicand(s_radicand), .s_initial_guess(s_initial_guess),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_root(m_root), .m_status(m_status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // ---------------- model ----------------
    function automatic logic [63:0] heron_step(logic [63:0] x, logic [63:0] a);
        logic [63:0] q;
        if (x == 0)
            q = ROOT_MAX;
        else
            q = (a << FRAC_BITS) / x;
        if (q > ROOT_MAX)
            q = ROOT_MAX;
        return (x + q) >> 1;
    endfunction

    function automatic logic [63:0] abs_diff(logic [63:0] p, logic [63:0] q);
        return (p >= q) ? p - q : q - p;
    endfunction

    function automatic bit aitken_below(logic [63:0] x0, logic [63:0] x1, logic [63:0] x2);
        logic [127:0] err_num;
        logic [127:0] tol_den;
        logic [63:0]  den;
        den = abs_diff(x1 << 1, x0 + x2);
        if (den == 0)
            return 1'b0;
        err_num = 128'(abs_diff(x1, x0)) * 128'(abs_diff(x2, x1));
        tol_den = 128'(tol_q) * 128'(den);
        return err_num < tol_den;
    endfunction

    function automatic root_beat_t sqrt_predict(logic [31:0] rad, logic [31:0] guess);
        root_beat_t  r;
        logic [63:0] x0, x1, x2, a;
        int          n;
        r.root = '0;
        r.status = hsa_pkg::ST_LIMIT;
        a = 64'(rad);
        if (tol_q == 0) begin
            r.status = hsa_pkg::ST_BAD_TOL;
            return r;
        end
        if (guess[31]) begin
            r.status = hsa_pkg::ST_NEG_GUESS;
            return r;
        end
        if (rad[31]) begin
            r.status = hsa_pkg::ST_NEG_RAD;
            return r;
        end
        if (guess == 0) begin
            r.status = hsa_pkg::ST_ZERO_GUESS;
            return r;
        end
        x0 = 64'(guess);
        x1 = heron_step(x0, a);
        x2 = heron_step(x1, a);
        for (n = 2; n < int'(lim_q); n++) begin
            if (x1 == x0 || aitken_below(x0, x1, x2)) begin
                r.status = hsa_pkg::ST_OK;
                break;
            end
            x0 = x1;
            x1 = x2;
            x2 = heron_step(x1, a);
        end
        r.root = x2[31:0];
        return r;
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        root_beat_t exp_beat;
        if (aresetn && m_valid && m_ready) begin
            roots_seen++;
            if (pending_roots.size() == 0) begin
                report_mismatch("unexpected beat", m_root, 32'h0);
            end else begin
                exp_beat = pending_roots.pop_front();
                if (m_root !== exp_beat.root)
                    report_mismatch("root", m_root, exp_beat.root);
                if (m_status !== exp_beat.status)
                    report_mismatch("status", 32'(m_status), 32'(exp_beat.status));
            end
        end
    end

    // watchdog: cycles with no beat on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result-side ready: random bursts, long hold-offs on request
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            m_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else if (ready_run > 0) begin
            m_ready <= ~ready_idle;
            ready_run <= ready_run - 1;
        end else begin
            ready_idle <= ($urandom_range(0, 2) == 0);
            ready_run <= $urandom_range(1, 12);
            m_ready <= 1'b1;
        end
    end

    // ---------------- drivers ----------------
    task automatic send_root_item(logic [31:0] rad, logic [31:0] guess);
        int gap;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_radicand = rad;
        s_initial_guess = guess;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_roots.push_back(sqrt_predict(rad, guess));
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_roots.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        wait_drained();
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == hsa_pkg::CFG_TOLERANCE)
            tol_q = data[hsa_pkg::TOL_WIDTH-1:0];
        else
            lim_q = data[hsa_pkg::LIM_WIDTH-1:0];
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // non-negative operand with a random magnitude spread
    function automatic logic [31:0] rand_pos();
        return $urandom() & (32'h7FFF_FFFF >> $urandom_range(0, 30));
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        send_root_item(32'h0002_0000, 32'h0001_0000);
        send_root_item(32'h0004_0000, 32'h0002_0000);   // already at the root
        send_root_item(32'h0000_0000, 32'h0000_0001);   // iterate truncates to zero
        send_root_item(32'h0001_0000, 32'h8000_0000);   // negative guess
        send_root_item(32'h8000_0000, 32'h0001_0000);   // negative radicand
        send_root_item(32'h8000_0000, 32'hFFFF_FFFF);   // guess check wins
        send_root_item(32'h0001_0000, 32'h0000_0000);   // zero guess
        send_root_item(32'h8000_0000, 32'h0000_0000);   // radicand check wins
        send_root_item(32'h7FFF_FFFF, 32'h0000_0001);
        send_root_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_root_item(32'h0000_0001, 32'h7FFF_FFFF);
        send_root_item(32'h0000_0000, 32'h7FFF_FFFF);
        send_root_item(32'h5555_5555, 32'h2AAA_AAAA);
    endtask

    task automatic test_register_extremes();
        write_reg(hsa_pkg::CFG_TOLERANCE, 32'h8000_0000);  // low bits zero: bad tolerance
        send_root_item(32'h0002_0000, 32'h0001_0000);
        send_root_item(32'h8000_0000, 32'h8000_0000);
        write_reg(hsa_pkg::CFG_TOLERANCE, 32'h7FFF_FFFF);
        send_root_item(32'h0009_0000, 32'h0001_0000);
        write_reg(hsa_pkg::CFG_LIMIT, 32'h0);
        send_root_item(32'h0009_0000, 32'h0001_0000);
        write_reg(hsa_pkg::CFG_LIMIT, 32'h1);
        send_root_item(32'h0009_0000, 32'h0001_0000);
        write_reg(hsa_pkg::CFG_LIMIT, 32'hFFFF_FF02);
        send_root_item(32'h0009_0000, 32'h0001_0000);
        write_reg(hsa_pkg::CFG_TOLERANCE, 32'h1);
        write_reg(hsa_pkg::CFG_LIMIT, 32'hFF);
        send_root_item(32'h7FFF_FFFF, 32'h0000_0001);
        send_root_item(32'h0002_0000, 32'h7FFF_FFFF);
        write_reg(hsa_pkg::CFG_LIMIT, 32'd3);
        send_root_item(32'h0002_0000, 32'h0000_0100);
    endtask

    task automatic test_back_pressure();
        int i;
        write_reg(hsa_pkg::CFG_TOLERANCE, 32'd66);
        write_reg(hsa_pkg::CFG_LIMIT, 32'd12);
        @(negedge aclk);
        // long enough for two items to finish and the third to stall
        hold_off = 3000;
        for (i = 0; i < 6; i++)
            send_root_item(rand_pos(), rand_pos() | 32'h1);
        wait_drained();
        // pause, then send into an empty block
        send_root_item(32'h0010_0000, 32'h0000_8000);
        wait_drained();
    endtask

    task automatic test_random(int count);
        int i, n;
        logic [31:0] rad, guess;
        for (i = 0; i < count; i += n) begin
            case ($urandom_range(0, 3))
                0: write_reg(hsa_pkg::CFG_TOLERANCE, $urandom_range(1, 200));
                1: write_reg(hsa_pkg::CFG_TOLERANCE, $urandom());
                2: write_reg(hsa_pkg::CFG_TOLERANCE, 32'(1) << $urandom_range(0, 31));
                default: write_reg(hsa_pkg::CFG_TOLERANCE, $urandom_range(0, 8));
            endcase
            write_reg(hsa_pkg::CFG_LIMIT,
                      ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 40));
            n = $urandom_range(10, 40);
            repeat (n) begin
                if (i > count * 4 / 5)
                    calm = 1'b1;
                if ($urandom_range(0, 9) == 0) begin
                    rad = $urandom();
                    guess = $urandom();
                end else begin
                    rad = rand_pos();
                    guess = rand_pos();
                    if (guess == 0 && $urandom_range(0, 1) == 1)
                        guess = 32'h1;
                end
                send_root_item(rad, guess);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_register_extremes();
        test_back_pressure();
        test_random(460);
        wait_drained();
        repeat (50) @(posedge aclk);
        $display("Covered %0d items, %0d register writes, %0d root beats checked.",
                 items_sent, cfg_writes, roots_seen);
        $display("Errors, saturation, limits 0..255 and tolerance extremes exercised.");
        if (mismatches == 0 && pending_roots.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
